FILE: hw/rtl/pebpu_pkg.sv
// ----------------------------------------------------------------------------
// pebpu_pkg
// Shared types and constants of the Pauli error backward propagation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pebpu_pkg;

  // Sizing of the row stores
  localparam int NUM_QUBITS = 64;
  localparam int ROW_BITS   = 64;
  localparam int QADDR_W    = $clog2(NUM_QUBITS);

  // Field widths of the stream items
  localparam int QUBIT_W    = 6;
  localparam int MASK_W     = 64;
  localparam int TYPE_W     = 3;
  localparam int CNT_W      = 16;
  localparam int ROW_OUT_W  = 64;
  localparam int S_TDATA_W  = 80;
  localparam int M_TDATA_W  = 208;
  localparam int S_TUSER_W  = TYPE_W;
  localparam int M_TUSER_W  = 1;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_NOISE_LOCS = 1'b0;
  localparam logic [CNT_W-1:0] NOISE_LOCS_RST = 16'd1;

  typedef enum logic [TYPE_W-1:0] {
    REQ_DEPOLARIZE = 3'd0,
    REQ_MEASURE    = 3'd1,
    REQ_RESET      = 3'd2,
    REQ_CNOT       = 3'd3,
    REQ_HADAMARD   = 3'd4
  } req_e;

  typedef logic [ROW_BITS-1:0] row_t;
  typedef logic [QADDR_W-1:0]  qaddr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pebpu_ram.sv
// ----------------------------------------------------------------------------
// pebpu_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pebpu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pauli_error_backward_propagation_unit.sv
// ----------------------------------------------------------------------------
// pauli_error_backward_propagation_unit
// Propagates Pauli errors backward through a gate stream and reports, for
// every depolarizing noise location, the detector rows of its qubit.
// ----------------------------------------------------------------------------
// Gates enter in reverse circuit order; a new gate is not accepted while one
// is held. The X, Y and Z rows sit in three dual-read memories: a gate's rows
// are read at the edge it is accepted and written back in the following
// cycle, and only then is the next gate taken. A CNOT writes its second Y row
// later still from the s2 register, in the cycle the next gate can be read;
// that row is forwarded. A depolarize result passes from the held gate into
// the output register once that register can take it, and the next
// gate is taken while it waits. Rows start cleared through per-row valid
// flops, so no clearing pass runs after reset. Writing the noise location
// count restarts the noise index countdown.
// ----------------------------------------------------------------------------
`default_nettype none

module pauli_error_backward_propagation_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // input gate stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [5:0] qubit_a, [11:6] qubit_b, [75:12] parity_mask, [79:76] zero
  input  wire logic [pebpu_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] req_type
  input  wire logic [pebpu_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [15:0] noise_index, [79:16] x_row, [143:80] y_row, [207:144] z_row
  output logic      [pebpu_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // [0] index_overflow
  output logic      [pebpu_pkg::M_TUSER_W-1:0]  m_axis_tuser,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pebpu_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [pebpu_pkg::PDATA_W-1:0]    pwdata,
  output logic      [pebpu_pkg::PDATA_W-1:0]    prdata,
  output logic                                  pready
);

  localparam int NQ = pebpu_pkg::NUM_QUBITS;
  localparam int QW = pebpu_pkg::QUBIT_W;
  localparam int CW = pebpu_pkg::CNT_W;

  // --------------------------------------------------------------------------
  // Input unpacking
  // --------------------------------------------------------------------------
  logic [QW-1:0]                   in_qa, in_qb;
  logic [pebpu_pkg::MASK_W-1:0]    in_mask;
  pebpu_pkg::qaddr_t               in_addr_a, in_addr_b;
  logic                            in_inr_a, in_inr_b;
  logic                            accept;

  assign in_qa     = s_axis_tdata[QW-1:0];
  assign in_qb     = s_axis_tdata[2*QW-1:QW];
  assign in_mask   = s_axis_tdata[2*QW+pebpu_pkg::MASK_W-1:2*QW];
  assign in_addr_a = pebpu_pkg::QADDR_W'(in_qa);
  assign in_addr_b = pebpu_pkg::QADDR_W'(in_qb);
  assign in_inr_a  = 32'(in_qa) < NQ;
  assign in_inr_b  = 32'(in_qb) < NQ;
  assign accept    = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  logic                      s1_valid_q, s1_valid_d;
  pebpu_pkg::req_e           s1_type_q;
  pebpu_pkg::qaddr_t         s1_qa_q, s1_qb_q;
  logic                      s1_inr_a_q, s1_inr_b_q, s1_same_q;
  pebpu_pkg::row_t           s1_mask_q;
  logic [5:0]                s1_vld_q;   // {z_b, z_a, y_b, y_a, x_b, x_a}

  logic                      s2_valid_q, s2_valid_d;
  pebpu_pkg::qaddr_t         s2_addr_q, s2_addr_d;
  pebpu_pkg::row_t           s2_data_q, s2_data_d;

  logic                      fwd_valid_q;
  pebpu_pkg::qaddr_t         fwd_addr_q;
  pebpu_pkg::row_t           fwd_data_q;

  logic [NQ-1:0]             x_vld_q, x_vld_d;
  logic [NQ-1:0]             y_vld_q, y_vld_d;
  logic [NQ-1:0]             z_vld_q, z_vld_d;

  logic [CW-1:0]             noise_locs_q, noise_locs_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic                      exh_q, exh_d;

  logic                      out_valid_q, out_valid_d;
  logic [pebpu_pkg::M_TDATA_W-1:0] out_data_q, out_data_d;
  logic                      out_ovf_q, out_ovf_d;

  // --------------------------------------------------------------------------
  // Row memories
  // --------------------------------------------------------------------------
  logic              x_we, y_we, z_we;
  pebpu_pkg::qaddr_t x_wa, y_wa, z_wa;
  pebpu_pkg::row_t   x_wd, y_wd, z_wd;
  pebpu_pkg::row_t   x_rd_a, x_rd_b, y_rd_a, y_rd_b, z_rd_a, z_rd_b;

  pebpu_ram #(.WIDTH(pebpu_pkg::ROW_BITS), .DEPTH(NQ)) u_x_ram (
    .clk_i     (clk_i),
    .we_i      (x_we),
    .waddr_i   (x_wa),
    .wdata_i   (x_wd),
    .re_i      (accept),
    .raddr_a_i (in_addr_a),
    .raddr_b_i (in_addr_b),
    .rdata_a_o (x_rd_a),
    .rdata_b_o (x_rd_b)
  );

  pebpu_ram #(.WIDTH(pebpu_pkg::ROW_BITS), .DEPTH(NQ)) u_y_ram (
    .clk_i     (clk_i),
    .we_i      (y_we),
    .waddr_i   (y_wa),
    .wdata_i   (y_wd),
    .re_i      (accept),
    .raddr_a_i (in_addr_a),
    .raddr_b_i (in_addr_b),
    .rdata_a_o (y_rd_a),
    .rdata_b_o (y_rd_b)
  );

  pebpu_ram #(.WIDTH(pebpu_pkg::ROW_BITS), .DEPTH(NQ)) u_z_ram (
    .clk_i     (clk_i),
    .we_i      (z_we),
    .waddr_i   (z_wa),
    .wdata_i   (z_wd),
    .re_i      (accept),
    .raddr_a_i (in_addr_a),
    .raddr_b_i (in_addr_b),
    .rdata_a_o (z_rd_a),
    .rdata_b_o (z_rd_b)
  );

  // --------------------------------------------------------------------------
  // Read side: apply valid flags, range and forwarding
  // --------------------------------------------------------------------------
  pebpu_pkg::row_t xa, xb, ya, yb, za, zb;
  logic            s1_go;
  logic            cfg_we;
  logic            y1_we;
  pebpu_pkg::row_t y1_wd;

  always_comb begin
    xa = (s1_inr_a_q && s1_vld_q[0]) ? x_rd_a : '0;
    xb = (s1_inr_b_q && s1_vld_q[1]) ? x_rd_b : '0;
    ya = (s1_inr_a_q && s1_vld_q[2]) ? y_rd_a : '0;
    yb = (s1_inr_b_q && s1_vld_q[3]) ? y_rd_b : '0;
    za = (s1_inr_a_q && s1_vld_q[4]) ? z_rd_a : '0;
    zb = (s1_inr_b_q && s1_vld_q[5]) ? z_rd_b : '0;
    // take the Y row written in the same cycle as this gate's read
    if (fwd_valid_q && s1_inr_a_q && fwd_addr_q == s1_qa_q) begin
      ya = fwd_data_q;
    end
    if (fwd_valid_q && s1_inr_b_q && fwd_addr_q == s1_qb_q) begin
      yb = fwd_data_q;
    end
  end

  // hold the gate while a depolarize result cannot enter the output register
  assign s1_go = s1_valid_q &&
                 !(s1_type_q == pebpu_pkg::REQ_DEPOLARIZE && out_valid_q && !m_axis_tready);
  assign s_axis_tready = !s1_valid_q;

  // --------------------------------------------------------------------------
  // Modify and write back
  // --------------------------------------------------------------------------
  always_comb begin
    x_we      = 1'b0;
    z_we      = 1'b0;
    y1_we     = 1'b0;
    x_wa      = s1_qa_q;
    z_wa      = s1_qa_q;
    x_wd      = '0;
    z_wd      = '0;
    y1_wd     = '0;
    s2_valid_d = 1'b0;
    s2_addr_d  = s1_qb_q;
    s2_data_d  = yb ^ za;
    if (s1_go) begin
      unique case (s1_type_q)
        pebpu_pkg::REQ_MEASURE: begin
          x_we  = s1_inr_a_q;
          x_wd  = xa | s1_mask_q;
          y1_we = s1_inr_a_q;
          y1_wd = ya | s1_mask_q;
        end
        pebpu_pkg::REQ_RESET: begin
          x_we  = s1_inr_a_q;
          y1_we = s1_inr_a_q;
          z_we  = s1_inr_a_q;
        end
        pebpu_pkg::REQ_CNOT: begin
          x_we  = s1_inr_a_q;
          x_wd  = xa ^ xb;
          z_we  = s1_inr_b_q;
          z_wa  = s1_qb_q;
          z_wd  = zb ^ za;
          // on a single qubit the Y row stays as it is
          y1_we = s1_inr_a_q && !s1_same_q;
          y1_wd = ya ^ xb;
          s2_valid_d = s1_inr_b_q && !s1_same_q;
        end
        pebpu_pkg::REQ_HADAMARD: begin
          x_we = s1_inr_a_q;
          x_wd = za;
          z_we = s1_inr_a_q;
          z_wd = xa;
        end
        default: begin
        end
      endcase
    end
  end

  // the deferred Y write and a first-cycle Y write never share a cycle
  always_comb begin
    if (s2_valid_q) begin
      y_we = 1'b1;
      y_wa = s2_addr_q;
      y_wd = s2_data_q;
    end else begin
      y_we = y1_we;
      y_wa = s1_qa_q;
      y_wd = y1_wd;
    end
  end

  always_comb begin
    x_vld_d = x_vld_q;
    y_vld_d = y_vld_q;
    z_vld_d = z_vld_q;
    if (x_we) x_vld_d[x_wa] = 1'b1;
    if (y_we) y_vld_d[y_wa] = 1'b1;
    if (z_we) z_vld_d[z_wa] = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Noise countdown, output register, configuration
  // --------------------------------------------------------------------------
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[2] == pebpu_pkg::REG_NOISE_LOCS);

  always_comb begin
    noise_locs_d  = noise_locs_q;
    cnt_d         = cnt_q;
    exh_d         = exh_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_data_d    = out_data_q;
    out_ovf_d     = out_ovf_q;
    s1_valid_d    = s1_valid_q;
    if (s1_go) begin
      s1_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
    end
    if (s1_go && s1_type_q == pebpu_pkg::REQ_DEPOLARIZE) begin
      out_valid_d = 1'b1;
      out_data_d  = {pebpu_pkg::ROW_OUT_W'(za), pebpu_pkg::ROW_OUT_W'(ya),
                     pebpu_pkg::ROW_OUT_W'(xa), cnt_q};
      out_ovf_d   = exh_q;
      if (cnt_q == '0) begin
        exh_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CW'(1);
      end
    end
    if (cfg_we) begin
      noise_locs_d = pwdata[CW-1:0];
      if (pwdata[CW-1:0] == '0) begin
        cnt_d = '0;
        exh_d = 1'b1;
      end else begin
        cnt_d = pwdata[CW-1:0] - CW'(1);
        exh_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      fwd_valid_q   <= 1'b0;
      x_vld_q       <= '0;
      y_vld_q       <= '0;
      z_vld_q       <= '0;
      noise_locs_q  <= pebpu_pkg::NOISE_LOCS_RST;
      cnt_q         <= pebpu_pkg::NOISE_LOCS_RST - CW'(1);
      exh_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      s1_valid_q    <= s1_valid_d;
      s2_valid_q    <= s2_valid_d;
      x_vld_q       <= x_vld_d;
      y_vld_q       <= y_vld_d;
      z_vld_q       <= z_vld_d;
      noise_locs_q  <= noise_locs_d;
      cnt_q         <= cnt_d;
      exh_q         <= exh_d;
      out_valid_q   <= out_valid_d;
      if (accept) begin
        fwd_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s2_addr_q <= s2_addr_d;
    s2_data_q <= s2_data_d;
    out_data_q <= out_data_d;
    out_ovf_q  <= out_ovf_d;
    if (accept) begin
      s1_type_q  <= pebpu_pkg::req_e'(s_axis_tuser);
      s1_qa_q    <= in_addr_a;
      s1_qb_q    <= in_addr_b;
      s1_inr_a_q <= in_inr_a;
      s1_inr_b_q <= in_inr_b;
      s1_same_q  <= in_qa == in_qb;
      s1_mask_q  <= in_mask[pebpu_pkg::ROW_BITS-1:0];
      // sample the valid flags together with the memory read
      s1_vld_q   <= {z_vld_q[in_addr_b], z_vld_q[in_addr_a],
                     y_vld_q[in_addr_b], y_vld_q[in_addr_a],
                     x_vld_q[in_addr_b], x_vld_q[in_addr_a]};
      fwd_addr_q <= s2_addr_q;
      fwd_data_q <= s2_data_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ovf_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pebpu_pkg::REG_NOISE_LOCS) ?
                  pebpu_pkg::PDATA_W'(noise_locs_q) : '0;

endmodule

`default_nettype wire

FILE: sim/noise_report_checker.sv
// ----------------------------------------------------------------------------
// noise_report_checker
// Watches the gate, result and register channels of the Pauli error backward
// propagation unit, keeps its own copy of the X/Y/Z row stores and the noise
// countdown, and compares every result transaction with the oldest report
// predicted from the accepted gates. Register reads are checked as well.
// ----------------------------------------------------------------------------
`default_nettype none

module noise_report_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  input  wire logic                             s_axis_tready,
  // [5:0] qubit_a, [11:6] qubit_b, [75:12] parity_mask, [79:76] zero
  input  wire logic [pebpu_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] req_type
  input  wire logic [pebpu_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  input  wire logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [15:0] noise_index, [79:16] x_row, [143:80] y_row, [207:144] z_row
  input  wire logic [pebpu_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // [0] index_overflow
  input  wire logic [pebpu_pkg::M_TUSER_W-1:0]  m_axis_tuser,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pebpu_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [pebpu_pkg::PDATA_W-1:0]    pwdata,
  input  wire logic [pebpu_pkg::PDATA_W-1:0]    prdata,
  input  wire logic                             pready,
  output int                                    mismatch_count_o,
  output int                                    reports_pending_o
);

  import pebpu_pkg::*;

  localparam logic [PADDR_W-1:0] NOISE_LOCS_ADDR = {REG_NOISE_LOCS, 2'b00};

  typedef struct packed {
    logic [CNT_W-1:0] index;
    row_t             x_row;
    row_t             y_row;
    row_t             z_row;
    logic             overflow;
  } noise_report_t;

  row_t             x_bank [NUM_QUBITS];
  row_t             y_bank [NUM_QUBITS];
  row_t             z_bank [NUM_QUBITS];
  logic [CNT_W-1:0] noise_locs;
  logic [CNT_W-1:0] noise_left;
  logic             noise_spent;
  noise_report_t    expected_reports [$];
  int               mismatch_count = 0;
  int               pending_count  = 0;

  assign mismatch_count_o  = mismatch_count;
  assign reports_pending_o = pending_count;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Restart the countdown; a zero count starts out exhausted.
  task automatic load_noise_locs(input logic [CNT_W-1:0] value);
    noise_locs  = value;
    noise_spent = (value == '0);
    noise_left  = (value == '0) ? '0 : value - 1'b1;
  endtask

  task automatic propagate_gate(input logic [TYPE_W-1:0] kind, input qaddr_t qa,
                                input qaddr_t qb, input row_t mask);
    noise_report_t rpt;
    row_t          swap;
    case (kind)
      REQ_DEPOLARIZE: begin
        rpt.index    = noise_left;
        rpt.x_row    = x_bank[qa];
        rpt.y_row    = y_bank[qa];
        rpt.z_row    = z_bank[qa];
        rpt.overflow = noise_spent;
        expected_reports.push_back(rpt);
        if (noise_left == '0) noise_spent = 1'b1;
        else noise_left = noise_left - 1'b1;
      end
      REQ_MEASURE: begin
        x_bank[qa] = x_bank[qa] | mask;
        y_bank[qa] = y_bank[qa] | mask;
      end
      REQ_RESET: begin
        x_bank[qa] = '0;
        y_bank[qa] = '0;
        z_bank[qa] = '0;
      end
      REQ_CNOT: begin
        // apply in sequence so that control == target clears X and Z
        x_bank[qa] = x_bank[qa] ^ x_bank[qb];
        z_bank[qb] = z_bank[qb] ^ z_bank[qa];
        y_bank[qa] = y_bank[qa] ^ x_bank[qb];
        y_bank[qb] = y_bank[qb] ^ z_bank[qa];
      end
      REQ_HADAMARD: begin
        swap       = x_bank[qa];
        x_bank[qa] = z_bank[qa];
        z_bank[qa] = swap;
      end
      default: ;
    endcase
  endtask

  task automatic check_report(input logic [M_TDATA_W-1:0] beat, input logic overflow);
    noise_report_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected, index %0d", beat[15:0]));
    end else begin
      want = expected_reports.pop_front();
      if (beat[15:0] !== want.index)
        report_mismatch($sformatf("noise_index got %0d want %0d", beat[15:0], want.index));
      if (beat[79:16] !== want.x_row)
        report_mismatch($sformatf("x_row got %h want %h", beat[79:16], want.x_row));
      if (beat[143:80] !== want.y_row)
        report_mismatch($sformatf("y_row got %h want %h", beat[143:80], want.y_row));
      if (beat[207:144] !== want.z_row)
        report_mismatch($sformatf("z_row got %h want %h", beat[207:144], want.z_row));
      if (overflow !== want.overflow)
        report_mismatch($sformatf("index_overflow got %b want %b", overflow, want.overflow));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < NUM_QUBITS; q++) begin
        x_bank[q] = '0;
        y_bank[q] = '0;
        z_bank[q] = '0;
      end
      load_noise_locs(NOISE_LOCS_RST);
      expected_reports.delete();
    end else begin
      if (psel && penable && pready && paddr == NOISE_LOCS_ADDR) begin
        if (pwrite) begin
          load_noise_locs(pwdata[CNT_W-1:0]);
        end else if (prdata !== PDATA_W'(noise_locs)) begin
          report_mismatch($sformatf("noise location count read %h want %h",
                                    prdata, noise_locs));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        propagate_gate(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[11:6],
                       s_axis_tdata[75:12]);
      if (m_axis_tvalid && m_axis_tready)
        check_report(m_axis_tdata, m_axis_tuser[0]);
    end
    pending_count = expected_reports.size();
  end

endmodule

`default_nettype wire

FILE: sim/pauli_error_backward_propagation_unit_tb.sv
// ----------------------------------------------------------------------------
// pauli_error_backward_propagation_unit_tb
// Drives gate streams into the propagation unit and gives the verdict.
// ----------------------------------------------------------------------------
// A directed part walks the countdown limits, every gate kind, CNOT with the
// same qubit on both ends and the ignored gate codes. Random phases follow,
// each under a new noise location count written while the unit is idle, with
// random gaps on the gate side and random stalls on the result side in every
// phase but the third. Prediction and comparison live in noise_report_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module pauli_error_backward_propagation_unit_tb;

  import pebpu_pkg::*;

  localparam logic [PADDR_W-1:0] NOISE_LOCS_ADDR = {REG_NOISE_LOCS, 2'b00};
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_GATES  = 190;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [PADDR_W-1:0]   paddr         = '0;
  logic [PDATA_W-1:0]   pwdata        = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  logic jitter_on    = 1'b1;
  int   mismatch_count;
  int   reports_pending;
  int   quiet_cycles = 0;

  pauli_error_backward_propagation_unit dut (.*);

  noise_report_checker u_checker (
    .*,
    .mismatch_count_o  (mismatch_count),
    .reports_pending_o (reports_pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) m_axis_tready <= !jitter_on || ($urandom_range(99) >= 13);

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[pauli_error_backward_propagation_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [QUBIT_W-1:0] pick_qubit();
    // favor a few qubits so gates interact
    return ($urandom_range(9) < 7) ? QUBIT_W'($urandom_range(7)) : QUBIT_W'($urandom);
  endfunction

  function automatic row_t random_mask();
    row_t m;
    m = {$urandom, $urandom};
    case ($urandom_range(2))
      0: m = m & {$urandom, $urandom} & {$urandom, $urandom};
      1: m = row_t'(1) << $urandom_range(ROW_BITS - 1);
      default: ;
    endcase
    return m;
  endfunction

  task automatic send_gate(input logic [TYPE_W-1:0] kind, input logic [QUBIT_W-1:0] qa,
                           input logic [QUBIT_W-1:0] qb, input row_t mask);
    if (jitter_on && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, mask, qb, qa};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random_gate();
    int unsigned         pick;
    logic [TYPE_W-1:0]   kind;
    logic [QUBIT_W-1:0]  qa;
    logic [QUBIT_W-1:0]  qb;
    pick = $urandom_range(99);
    if (pick < 26)      kind = REQ_DEPOLARIZE;
    else if (pick < 50) kind = REQ_MEASURE;
    else if (pick < 58) kind = REQ_RESET;
    else if (pick < 80) kind = REQ_CNOT;
    else if (pick < 92) kind = REQ_HADAMARD;
    else                kind = REQ_HADAMARD + TYPE_W'($urandom_range(1, 3));
    qa = pick_qubit();
    qb = ($urandom_range(9) == 0) ? qa : pick_qubit();
    send_gate(kind, qa, qb, random_mask());
  endtask

  task automatic apb_access(input logic is_write, input logic [CNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= NOISE_LOCS_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the gate side until every report is in, then let the CNOT tail settle.
  task automatic drain_reports(input int tail);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (reports_pending != 0);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic retune(input logic [CNT_W-1:0] value);
    drain_reports(8);
    apb_access(1'b1, value);
    apb_access(1'b0, '0);
  endtask

  initial begin
    logic [CNT_W-1:0] noise_count;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // countdown at its reset value of one: second report overflows
    apb_access(1'b0, '0);
    send_gate(REQ_DEPOLARIZE, '0, '0, '0);
    send_gate(REQ_DEPOLARIZE, '1, '1, '1);

    retune(16'hFFFF);
    send_gate(REQ_MEASURE, 6'd0, 6'd63, '1);
    send_gate(REQ_MEASURE, 6'd63, 6'd0, 64'hA5A5_5A5A_F00F_0FF0);
    send_gate(REQ_MEASURE, 6'd5, 6'd9, 64'h8000_0000_0000_0001);
    send_gate(REQ_HADAMARD, 6'd0, 6'd0, '0);
    send_gate(REQ_CNOT, 6'd0, 6'd63, '0);
    send_gate(REQ_CNOT, 6'd5, 6'd5, '1);
    send_gate(REQ_CNOT, 6'd63, 6'd0, '0);
    send_gate(REQ_DEPOLARIZE, 6'd0, 6'd5, '0);
    send_gate(REQ_DEPOLARIZE, 6'd63, 6'd0, '0);
    send_gate(REQ_DEPOLARIZE, 6'd5, 6'd63, '0);
    send_gate(REQ_RESET, 6'd63, 6'd63, '1);
    send_gate(REQ_DEPOLARIZE, 6'd63, 6'd1, '0);
    send_gate(REQ_MEASURE, 6'd7, 6'd7, '0);
    for (int k = 1; k <= 3; k++)
      send_gate(REQ_HADAMARD + TYPE_W'(k), 6'd0, 6'd63, random_mask());
    send_gate(REQ_DEPOLARIZE, 6'd0, 6'd0, '0);

    // zero locations: exhausted from the first report
    retune('0);
    send_gate(REQ_DEPOLARIZE, 6'd1, 6'd0, '0);
    send_gate(REQ_DEPOLARIZE, 6'd0, 6'd0, '0);

    retune(16'd3);
    send_gate(REQ_DEPOLARIZE, 6'd0, 6'd0, '0);
    send_gate(REQ_DEPOLARIZE, 6'd5, 6'd0, '0);
    send_gate(REQ_DEPOLARIZE, 6'd63, 6'd0, '0);
    send_gate(REQ_DEPOLARIZE, 6'd0, 6'd0, '0);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       noise_count = CNT_W'($urandom_range(1, 20));
        1:       noise_count = 16'hFFFF;
        2:       noise_count = CNT_W'($urandom_range(21, 400));
        3:       noise_count = CNT_W'($urandom_range(1, 8));
        4:       noise_count = CNT_W'($urandom_range(1, 65535));
        default: noise_count = CNT_W'($urandom_range(1, 60));
      endcase
      retune(noise_count);
      jitter_on <= (phase != 2);
      repeat (PHASE_GATES) send_random_gate();
    end

    drain_reports(10);
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("[pauli_error_backward_propagation_unit] OK");
    end else begin
      $display("[pauli_error_backward_propagation_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/pebpu_pkg.sv
hw/rtl/pebpu_ram.sv
hw/rtl/pauli_error_backward_propagation_unit.sv
sim/noise_report_checker.sv
sim/pauli_error_backward_propagation_unit_tb.sv
